### hw/rtl/bhpq_pkg.sv
`default_nettype none

package bhpq_pkg;

  // Number of entries that the heap can hold.
  localparam int CAPACITY = 64;

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  // Wide enough for the right child index 2*i+2 of any slot.
  localparam int CHILD_W = ADDR_W + 2;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0]        addr_t;
  typedef logic [CNT_W-1:0]         count_t;
  typedef logic [CHILD_W-1:0]       child_t;

  // Operation codes of an input item.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Value reported as the top when the queue is empty.
  localparam data_t EMPTY_TOP = -data_t'(1);

  // True when a must sit above b under the selected order (strict compare).
  function automatic logic ranks_above(input data_t a, input data_t b, input logic min_order);
    logic res;
    begin
      if (min_order) begin
        res = (a < b);
      end else begin
        res = (a > b);
      end
      return res;
    end
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bhpq_ram.sv
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]                 wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic      [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hw/rtl/binary_heap_priority_queue_core.sv
`default_nettype none

// Channel     Direction  Transfer condition        Payload
// ----------  ---------  ------------------------  -----------------------------------------
// input       in         start && !busy            in_op, in_value
// result      out        out_strobe (one cycle)    out_top_value, out_is_empty,
//                                                  out_push_dropped
// config      in         cfg_wr_en                 cfg_wr_data (min_order)
//
// One item is in flight at a time; busy stays high until its result transfer is issued.
// A push moves the new value up the heap a level at a time until it settles.
// A pop sinks the former last entry from the root; the heap RAM has one read port, so each
// level of the sift-down reads the left and then the right child, one after the other.
// Synchronous active-low reset empties the queue and selects the max ordering; the heap RAM
// itself is not cleared, since only slots below the entry count are ever used.
// The receiver cannot stall: each result is shown for exactly one cycle.

module binary_heap_priority_queue_core
  import bhpq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_op,
  input  wire data_t       in_value,
  output logic             out_strobe,
  output data_t            out_top_value,
  output logic             out_is_empty,
  output logic             out_push_dropped,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data
);

  // Sequencer states. UP_* walk a pushed value toward the root, DN_* walk the
  // former last entry down from the root after a pop.
  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_UP_CMP  = 7'b0000010,
    ST_UP_WR   = 7'b0000100,
    ST_DN_LAST = 7'b0001000,
    ST_DN_L    = 7'b0010000,
    ST_DN_CMP  = 7'b0100000,
    ST_DN_WR   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  count_t count_r, count_nxt;
  logic   min_order_r;
  addr_t  idx_r, idx_nxt;      // Slot of the hole that the moving value occupies.
  data_t  val_r, val_nxt;      // The moving value; it is written only once it settles.
  data_t  lval_r, lval_nxt;    // Left child value during a sift-down step.
  data_t  root_r, root_nxt;    // Copy of slot 0, so the top needs no extra read.

  logic   out_strobe_r;
  data_t  out_top_r;
  logic   out_empty_r;
  logic   out_drop_r;

  logic   finish;
  logic   drop_nxt;

  logic   wr_en;
  addr_t  wr_addr;
  data_t  wr_data;
  addr_t  rd_addr;
  data_t  rd_data;

  logic   accept;
  addr_t  idx_m1;
  addr_t  parent;
  addr_t  new_parent;
  addr_t  parent_m1;
  count_t cnt_dec;
  child_t n_ext;
  child_t left_idx;
  child_t right_idx;
  logic   has_right;
  logic   left_wins;
  data_t  cand;
  logic   right_wins;
  addr_t  best_idx;
  data_t  best_val;
  child_t next_left;

  bhpq_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_heap_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);

  // Index arithmetic for the heap shape.
  assign idx_m1    = idx_r - addr_t'(1);
  assign parent    = idx_m1 >> 1;
  assign parent_m1 = parent - addr_t'(1);
  assign new_parent = parent_m1 >> 1;
  assign cnt_dec   = count_r - count_t'(1);
  assign n_ext     = child_t'(count_r);
  assign left_idx  = {1'b0, idx_r, 1'b1};
  assign right_idx = left_idx + child_t'(1);
  assign has_right = (right_idx < n_ext);

  // Sift-down choice: the left child beats the moving value, then the right
  // child beats whichever of those two won. Ties never move anything.
  assign left_wins  = ranks_above(lval_r, val_r, min_order_r);
  assign cand       = left_wins ? lval_r : val_r;
  assign right_wins = has_right && ranks_above(rd_data, cand, min_order_r);
  assign best_idx   = right_wins ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
  assign best_val   = right_wins ? rd_data : lval_r;
  assign next_left  = {1'b0, best_idx, 1'b1};

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    lval_nxt  = lval_r;
    finish    = 1'b0;
    drop_nxt  = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = val_r;
    rd_addr   = parent;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_PUSH) begin
            if (count_r == count_t'(CAPACITY)) begin
              drop_nxt = 1'b1;
              finish   = 1'b1;
            end else if (count_r == '0) begin
              // First entry goes straight to the root.
              count_nxt = count_t'(1);
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_data   = in_value;
              finish    = 1'b1;
            end else begin
              count_nxt = count_r + count_t'(1);
              idx_nxt   = count_r[ADDR_W-1:0];
              val_nxt   = in_value;
              rd_addr   = (count_r[ADDR_W-1:0] - addr_t'(1)) >> 1;
              state_nxt = ST_UP_CMP;
            end
          end else begin
            if (count_r == '0) begin
              finish = 1'b1;
            end else begin
              count_nxt = cnt_dec;
              if (cnt_dec == '0) begin
                finish = 1'b1;
              end else begin
                rd_addr   = cnt_dec[ADDR_W-1:0];
                state_nxt = ST_DN_LAST;
              end
            end
          end
        end
      end

      ST_UP_CMP: begin
        // rd_data holds the parent of the hole.
        if (ranks_above(val_r, rd_data, min_order_r)) begin
          wr_en   = 1'b1;
          wr_data = rd_data;
          idx_nxt = parent;
          if (parent == '0) begin
            state_nxt = ST_UP_WR;
          end else begin
            rd_addr = new_parent;
          end
        end else begin
          wr_en     = 1'b1;
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_UP_WR: begin
        wr_en     = 1'b1;
        finish    = 1'b1;
        state_nxt = ST_IDLE;
      end

      ST_DN_LAST: begin
        // rd_data holds the former last entry, which restarts at the root.
        val_nxt = rd_data;
        idx_nxt = '0;
        if (count_r > count_t'(1)) begin
          rd_addr   = addr_t'(1);
          state_nxt = ST_DN_L;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = '0;
          wr_data   = rd_data;
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_DN_L: begin
        lval_nxt  = rd_data;
        rd_addr   = right_idx[ADDR_W-1:0];
        state_nxt = ST_DN_CMP;
      end

      ST_DN_CMP: begin
        wr_en = 1'b1;
        if (left_wins || right_wins) begin
          wr_data = best_val;
          idx_nxt = best_idx;
          if (next_left < n_ext) begin
            rd_addr   = next_left[ADDR_W-1:0];
            state_nxt = ST_DN_L;
          end else begin
            state_nxt = ST_DN_WR;
          end
        end else begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_DN_WR: begin
        wr_en     = 1'b1;
        finish    = 1'b1;
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Track slot 0 alongside the RAM.
  always_comb begin
    root_nxt = root_r;
    if (wr_en && (wr_addr == '0)) begin
      root_nxt = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      min_order_r  <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= finish;
      if (cfg_wr_en) begin
        min_order_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    val_r  <= val_nxt;
    lval_r <= lval_nxt;
    root_r <= root_nxt;
    if (finish) begin
      out_top_r   <= (count_nxt == '0) ? EMPTY_TOP : root_nxt;
      out_empty_r <= (count_nxt == '0);
      out_drop_r  <= drop_nxt;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_top_value    = out_top_r;
  assign out_is_empty     = out_empty_r;
  assign out_push_dropped = out_drop_r;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import bhpq_pkg::*;

  // Largest and smallest signed values, used as the extremes of the value field.
  localparam data_t MAX_VAL = 32'sh7fff_ffff;
  localparam data_t MIN_VAL = 32'sh8000_0000;

  // A run of this many cycles with no transfer on either channel means the block hung.
  localparam int STALL_LIMIT = 2000;
  // After the last result the block gets this many more cycles to show a stray strobe.
  localparam int TAIL_CYCLES = 40;

  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 250;

  // One row of the directed table is either an item or a write of the order register.
  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct {
    row_kind_t kind;
    logic      op;
    data_t     value;
    logic      typed;
    data_t     top;
    logic      empty;
    logic      dropped;
  } heap_row_t;

  // What one result transfer carries.
  typedef struct {
    data_t top;
    logic  empty;
    logic  dropped;
  } heap_result_t;

  logic  clk;
  logic  rst_n;
  logic  start;
  logic  busy;
  logic  in_op;
  data_t in_value;
  logic  out_strobe;
  data_t out_top_value;
  logic  out_is_empty;
  logic  out_push_dropped;
  logic  cfg_wr_en;
  logic  cfg_wr_data;

  binary_heap_priority_queue_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_strobe       (out_strobe),
    .out_top_value    (out_top_value),
    .out_is_empty     (out_is_empty),
    .out_push_dropped (out_push_dropped),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  // The clock runs at 100 MHz: 5 ns high and 5 ns low.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Heap predictor. It keeps its own copy of the stored entries, the entry count
  // and the order bit, and applies each accepted item to them in the order the
  // block accepts them. Comparisons are strict and signed, so equal values never
  // trade places, and a change of order leaves the stored entries where they are.
  // ---------------------------------------------------------------------------
  data_t heap_mem [CAPACITY];
  int    heap_count;
  logic  min_first;

  function automatic logic outranks(input data_t a, input data_t b);
    return min_first ? (a < b) : (a > b);
  endfunction

  function automatic heap_result_t heap_apply(input logic op, input data_t value);
    heap_result_t res;
    data_t        held;
    int           idx;
    int           parent;
    int           best;
    int           lchild;
    int           rchild;
    logic         settled;
    res.dropped = 1'b0;
    if (op == OP_PUSH) begin
      if (heap_count >= CAPACITY) begin
        // A full queue refuses the push and keeps its contents.
        res.dropped = 1'b1;
      end else begin
        idx = heap_count;
        heap_mem[idx] = value;
        heap_count++;
        settled = 1'b0;
        while (idx > 0 && !settled) begin
          parent = (idx - 1) / 2;
          if (outranks(heap_mem[idx], heap_mem[parent])) begin
            held = heap_mem[idx];
            heap_mem[idx] = heap_mem[parent];
            heap_mem[parent] = held;
            idx = parent;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end else if (heap_count > 0) begin
      // The last entry moves to the root and sinks until both children rank below it.
      heap_count--;
      heap_mem[0] = heap_mem[heap_count];
      idx = 0;
      settled = 1'b0;
      while (!settled) begin
        best = idx;
        lchild = 2 * idx + 1;
        rchild = 2 * idx + 2;
        if (lchild < heap_count && outranks(heap_mem[lchild], heap_mem[best])) begin
          best = lchild;
        end
        if (rchild < heap_count && outranks(heap_mem[rchild], heap_mem[best])) begin
          best = rchild;
        end
        if (best == idx) begin
          settled = 1'b1;
        end else begin
          held = heap_mem[idx];
          heap_mem[idx] = heap_mem[best];
          heap_mem[best] = held;
          idx = best;
        end
      end
    end
    // A pop of an empty queue falls through to here with nothing changed.
    if (heap_count == 0) begin
      res.top = EMPTY_TOP;
      res.empty = 1'b1;
    end else begin
      res.top = heap_mem[0];
      res.empty = 1'b0;
    end
    return res;
  endfunction

  // Results still owed by the block, oldest first.
  heap_result_t pending_results [$];
  int           mismatches;
  int           idle_cycles;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    // Past the first few dozen lines a broken block would only repeat itself.
    if (mismatches <= 40) begin
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, field, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor. The receiver cannot hold results off, so every cycle with the
  // strobe high is a transfer, and it is checked against the oldest expectation.
  // It samples at the rising edge, before any nonblocking update of that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result transfer", out_top_value, 32'h0);
      end else begin
        want = pending_results.pop_front();
        if (out_top_value !== want.top) begin
          report_mismatch("top_value", out_top_value, want.top);
        end
        if (out_is_empty !== want.empty) begin
          report_mismatch("is_empty", 32'(out_is_empty), 32'(want.empty));
        end
        if (out_push_dropped !== want.dropped) begin
          report_mismatch("push_dropped", 32'(out_push_dropped), 32'(want.dropped));
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count of quiet cycles.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_strobe === 1'b1 || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender. Items go out in bursts: within a burst start stays high and a new item
  // follows each accepted one at once, and between bursts start drops for a
  // random gap. Every drive happens right after a rising edge, as a nonblocking
  // assignment, and start gets at most one assignment per time step.
  // ---------------------------------------------------------------------------
  int burst_left;

  task automatic send_item(input logic op, input data_t value, input logic typed,
                           input heap_result_t typed_result);
    heap_result_t predicted;
    int           gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Now and then a long burst leaves the block no breathing room at all.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 16);
    end
    burst_left--;
    start <= 1'b1;
    in_op <= op;
    in_value <= value;
    // The transfer happens at the first edge at which busy is low.
    do @(posedge clk); while (busy !== 1'b0);
    predicted = heap_apply(op, value);
    pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
  endtask

  // Brings the block to rest: no item in flight and no result outstanding.
  task automatic drain_block();
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0 || busy !== 1'b0);
  endtask

  task automatic write_order(input logic order);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    min_first = order;
    cfg_wr_en <= 1'b0;
  endtask

  // A random value: mostly uniform, often from a narrow band so that equal
  // values meet in the heap, and sometimes one of the extremes, -1 or zero.
  function automatic data_t pick_value();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      return data_t'($urandom);
    end else if (kind <= 8) begin
      return data_t'($urandom_range(0, 6)) - 3;
    end
    case ($urandom_range(0, 3))
      0: return MAX_VAL;
      1: return MIN_VAL;
      2: return EMPTY_TOP;
      default: return '0;
    endcase
  endfunction

  // Directed table. Expected results are typed in where they are plain to see;
  // the other rows go through the predictor. The register is changed while the
  // heap still holds entries, so later sifts work under the new order.
  heap_row_t directed [22];

  initial begin
    heap_result_t typed_result;
    int           push_pct [RANDOM_PHASES];
    logic         op;

    start = 1'b0;
    in_op = OP_PUSH;
    in_value = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    rst_n = 1'b0;
    mismatches = 0;
    burst_left = 0;
    heap_count = 0;
    min_first = 1'b0;

    directed = '{
      // A pop right after reset finds the queue empty.
      '{ROW_ITEM, OP_POP,  MAX_VAL,   1'b1, EMPTY_TOP, 1'b1, 1'b0},
      '{ROW_ITEM, OP_PUSH, MAX_VAL,   1'b1, MAX_VAL,   1'b0, 1'b0},
      '{ROW_ITEM, OP_PUSH, MIN_VAL,   1'b1, MAX_VAL,   1'b0, 1'b0},
      '{ROW_ITEM, OP_PUSH, EMPTY_TOP, 1'b1, MAX_VAL,   1'b0, 1'b0},
      // An equal value must not displace the root.
      '{ROW_ITEM, OP_PUSH, MAX_VAL,   1'b1, MAX_VAL,   1'b0, 1'b0},
      '{ROW_ITEM, OP_PUSH, '0,        1'b1, MAX_VAL,   1'b0, 1'b0},
      '{ROW_ITEM, OP_POP,  '0,        1'b0, '0,        1'b0, 1'b0},
      '{ROW_ITEM, OP_POP,  MIN_VAL,   1'b0, '0,        1'b0, 1'b0},
      // Switch to smallest-first with three entries still stored.
      '{ROW_CFG,  OP_PUSH, 32'sd1,    1'b0, '0,        1'b0, 1'b0},
      '{ROW_ITEM, OP_PUSH, 32'sd5,    1'b0, '0,        1'b0, 1'b0},
      '{ROW_ITEM, OP_POP,  '0,        1'b0, '0,        1'b0, 1'b0},
      '{ROW_ITEM, OP_POP,  '0,        1'b0, '0,        1'b0, 1'b0},
      '{ROW_ITEM, OP_POP,  '0,        1'b0, '0,        1'b0, 1'b0},
      '{ROW_ITEM, OP_POP,  '0,        1'b1, EMPTY_TOP, 1'b1, 1'b0},
      '{ROW_ITEM, OP_POP,  EMPTY_TOP, 1'b1, EMPTY_TOP, 1'b1, 1'b0},
      // A stored -1 looks like the empty marker; only is_empty tells them apart.
      '{ROW_ITEM, OP_PUSH, EMPTY_TOP, 1'b1, EMPTY_TOP, 1'b0, 1'b0},
      '{ROW_ITEM, OP_PUSH, MIN_VAL,   1'b1, MIN_VAL,   1'b0, 1'b0},
      '{ROW_ITEM, OP_PUSH, MAX_VAL,   1'b1, MIN_VAL,   1'b0, 1'b0},
      '{ROW_ITEM, OP_POP,  '0,        1'b1, EMPTY_TOP, 1'b0, 1'b0},
      '{ROW_ITEM, OP_POP,  '0,        1'b1, MAX_VAL,   1'b0, 1'b0},
      '{ROW_ITEM, OP_POP,  '0,        1'b1, EMPTY_TOP, 1'b1, 1'b0},
      '{ROW_CFG,  OP_PUSH, '0,        1'b0, '0,        1'b0, 1'b0}
    };

    // Phases lean toward pushes, which fill the queue and provoke dropped
    // pushes, or toward pops, which drain it and pop it while empty.
    push_pct = '{95, 30, 10, 85, 55, 5, 92, 45};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[row]) begin
      if (directed[row].kind == ROW_CFG) begin
        drain_block();
        write_order(directed[row].value[0]);
      end else begin
        typed_result.top = directed[row].top;
        typed_result.empty = directed[row].empty;
        typed_result.dropped = directed[row].dropped;
        send_item(directed[row].op, directed[row].value, directed[row].typed, typed_result);
      end
    end

    // Random part: each phase begins with a register write at rest. The first
    // phases alternate the two orders, the later ones draw it at random.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_block();
      write_order((phase < 4) ? phase[0] : 1'($urandom_range(0, 1)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        op = ($urandom_range(1, 100) <= push_pct[phase]) ? OP_PUSH : OP_POP;
        send_item(op, pick_value(), 1'b0, typed_result);
      end
    end

    drain_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
